// ===== hdl/ntse_pkg.sv =====
// Shared types, constants and tables for the note tone synthesiser.
// Used by every module of the block but the divider; depends on nothing else.
package ntse_pkg;

  // Default widths of the phase accumulator and the sine index
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_INDEX_BITS_DEF = 10;

  localparam int SPB_W      = 14;
  localparam logic [SPB_W-1:0] SPB_RESET = 14'd4000;
  localparam int LEN_W      = 16;
  localparam int STEP_W     = 32;
  localparam int FRONT_DIV_W = 24;
  localparam int BACK_DIV_W  = 32;
  localparam int QUEUE_DEPTH = 4;

  // Pitch codes with a special meaning
  localparam logic [7:0] PITCH_SKIP = 8'd32;
  localparam logic [7:0] PITCH_REST = 8'd95;
  localparam logic [7:0] PITCH_NUL  = 8'd0;

  // Wave polynomial and amplitude constants
  localparam logic [30:0] HORNER_INIT = 31'd172272;
  localparam logic [15:0] AMP_NUM     = 16'd56896;
  localparam logic [31:0] AMP_BIAS    = 32'd2684354560;
  localparam logic [15:0] DIV5_RECIP  = 16'd52429;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // One classified transaction on its way from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic              skip;
    logic              voiced;
    logic [STEP_W-1:0] step;
    logic [LEN_W-1:0]  sus_len;
    logic [LEN_W-1:0]  rel_len;
  } item_t;

  // Note length in 24ths of a beat
  function automatic logic [6:0] beat_24ths(input logic [7:0] code);
    logic [6:0] r;
    case (code)
      8'd87:   r = 7'd96;  // W
      8'd72:   r = 7'd72;  // H
      8'd104:  r = 7'd48;  // h
      8'd81:   r = 7'd36;  // Q
      8'd84:   r = 7'd32;  // T
      8'd113:  r = 7'd24;  // q
      8'd69:   r = 7'd18;  // E
      8'd116:  r = 7'd16;  // t
      8'd101:  r = 7'd12;  // e
      8'd83:   r = 7'd9;   // S
      8'd117:  r = 7'd8;   // u
      8'd115:  r = 7'd6;   // s
      8'd118:  r = 7'd4;   // v
      8'd32:   r = 7'd0;   // space
      default: r = 7'd24;
    endcase
    return r;
  endfunction

  // Phase step of each semitone above middle C at full 32-bit scale
  function automatic logic [27:0] semitone_step(input logic [3:0] k);
    logic [27:0] r;
    case (k)
      4'd0:    r = 28'd140459156;
      4'd1:    r = 28'd148811292;
      4'd2:    r = 28'd157660072;
      4'd3:    r = 28'd167035027;
      4'd4:    r = 28'd176967447;
      4'd5:    r = 28'd187490479;
      4'd6:    r = 28'd198639243;
      4'd7:    r = 28'd210450947;
      4'd8:    r = 28'd222965011;
      4'd9:    r = 28'd236223201;
      4'd10:   r = 28'd250269763;
      4'd11:   r = 28'd265151578;
      default: r = 28'd0;
    endcase
    return r;
  endfunction

  // Horner coefficients of the sine polynomial, highest order first
  function automatic logic [30:0] horner_coef(input logic [1:0] i);
    logic [30:0] r;
    case (i)
      2'd0:    r = 31'd5026995;
      2'd1:    r = 31'd85569306;
      2'd2:    r = 31'd693598668;
      default: r = 31'd1686629713;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/note_tone_synth_envelope.sv =====
// Note tone synthesiser: a load transaction (command 0) sets pitch, length and
// staccato of a new note, and each tick transaction (command 1) returns one signed
// 8-bit sine sample with a linear release tail. A front part splits the pitch and
// works out length and release with reciprocal multiplies, one step per cycle, and
// holds its input stalled until each transaction is queued, waiting while the queue
// is full. A four-entry queue decouples it from the back part, which divides by the
// release envelope in its iterative divider on release ticks; rest ticks and idle
// ticks skip the wave evaluation. samples_per_beat is written through cfg_we_i /
// cfg_data_i and resets to 4000.
module note_tone_synth_envelope #(
  parameter int PHASE_BITS      = ntse_pkg::PHASE_BITS_DEF,
  parameter int SINE_INDEX_BITS = ntse_pkg::SINE_INDEX_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ntse_pkg::SPB_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [7:0]                 pitch_code_i,
  input  logic [7:0]                 duration_code_i,
  input  logic                       staccato_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [7:0]          sample_o,
  output logic                       note_last_o,
  output logic                       idle_o
);

  logic [ntse_pkg::SPB_W-1:0] spb_q;
  logic                       push, full, pop, empty;
  ntse_pkg::item_t            push_item, pop_item;
  logic [7:0]                 sample;

  // Hold the samples-per-beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q <= ntse_pkg::SPB_RESET;
    end else if (cfg_we_i) begin
      spb_q <= cfg_data_i;
    end
  end

  ntse_front #(.PHASE_BITS(PHASE_BITS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .spb_i           (spb_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .pitch_code_i    (pitch_code_i),
    .duration_code_i (duration_code_i),
    .staccato_i      (staccato_i),
    .push_o          (push),
    .push_item_o     (push_item),
    .full_i          (full)
  );

  ntse_fifo #(.DEPTH(ntse_pkg::QUEUE_DEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  ntse_back #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_INDEX_BITS (SINE_INDEX_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample),
    .note_last_o (note_last_o),
    .idle_o      (idle_o)
  );

  assign sample_o = $signed(sample);

endmodule

// ===== hdl/ntse_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the back part.
module ntse_div #(
  parameter int W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o,
  output logic [W-1:0] remainder_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d, rem_q, rem_d, dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;
  logic          ge;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    ge    = trial >= {1'b0, dvs_q};
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[W-2:0], ge};
      rem_d = ge ? W'(trial - {1'b0, dvs_q}) : trial[W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== hdl/ntse_front.sv =====
// Front part: accepts transactions and works out note length, release and step.
// Depends on ntse_pkg.
module ntse_front #(
  parameter int PHASE_BITS = ntse_pkg::PHASE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ntse_pkg::SPB_W-1:0] spb_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [7:0]                 pitch_code_i,
  input  logic [7:0]                 duration_code_i,
  input  logic                       staccato_i,
  output logic                       push_o,
  output ntse_pkg::item_t            push_item_o,
  input  logic                       full_i
);

  localparam int PB_OFF = 32 - PHASE_BITS;

  // Reciprocals for the constant divisions by 12 and by 3
  localparam logic [11:0] DIV12_RECIP = 12'd2731;
  localparam logic [17:0] DIV3_RECIP  = 18'd174763;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_OCT  = 7'b0000010,
    F_MUL  = 7'b0000100,
    F_LEN  = 7'b0001000,
    F_REL  = 7'b0010000,
    F_STEP = 7'b0100000,
    F_PUSH = 7'b1000000
  } fstate_e;

  fstate_e state_q, state_d;

  ntse_pkg::cmd_e                 cmd_q;
  logic [7:0]                     pitch_q, dur_q;
  logic                           stacc_q;
  logic [4:0]                     oct_q, oct_d;
  logic [3:0]                     semi_q, semi_d;
  logic [20:0]                    prod_q;
  logic [ntse_pkg::LEN_W-1:0]     len_q, rel_q, len_d, rel_d;
  logic [ntse_pkg::STEP_W-1:0]    step_q, step_d;

  logic          accept;

  logic [8:0]        pm;
  logic [20:0]       pm_prod;
  logic [17:0]       len_b;
  logic [35:0]       len_prod;
  logic [18:0]       rel_num;
  logic [17:0]       rel_half;
  logic [33:0]       rel_prod;

  logic signed [6:0] shift;
  logic [5:0]        nsh;
  logic [47:0]       base, scaled;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);

  // Split the pitch into octave and semitone by a reciprocal multiply
  always_comb begin
    pm      = 9'(pitch_q) + 9'd8;
    pm_prod = 21'(pm) * 21'(DIV12_RECIP);
    oct_d   = pm_prod[19:15];
    semi_d  = 4'(pm - 9'(oct_d) * 9'd12);
  end

  // Divide the length by 24 (shift right by 3, then divide by 3) and the release by 10
  always_comb begin
    len_b    = 18'((prod_q + 21'd12) >> 3);
    len_prod = 36'(len_b) * 36'(DIV3_RECIP);
    len_d    = len_prod[34:19];
    rel_num  = stacc_q ? ((19'(len_q) << 2) + 19'd5) : (19'(len_q) + 19'd5);
    rel_half = rel_num[18:1];
    rel_prod = 34'(rel_half) * 34'(ntse_pkg::DIV5_RECIP);
    rel_d    = rel_prod[33:18];
  end

  // Scale the semitone step by the octave, rounding halves up on a right shift
  always_comb begin
    shift  = $signed({2'b00, oct_q}) - 7'sd5 - 7'(PB_OFF);
    nsh    = 6'(-shift);
    base   = 48'(ntse_pkg::semitone_step(semi_q));
    if (!shift[6]) begin
      scaled = base << shift[4:0];
    end else begin
      scaled = (base + (48'd1 << (nsh - 6'd1))) >> nsh;
    end
    step_d = ntse_pkg::STEP_W'(scaled[PHASE_BITS-1:0]);
  end

  // Advance the classification sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = (command_i == ntse_pkg::CMD_LOAD) ? F_OCT : F_PUSH;
        end
      end
      F_OCT:  state_d = F_MUL;
      F_MUL:  state_d = F_LEN;
      F_LEN:  state_d = F_REL;
      F_REL:  state_d = F_STEP;
      F_STEP: state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the transaction and its worked-out fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= ntse_pkg::cmd_e'(command_i);
      pitch_q <= pitch_code_i;
      dur_q   <= duration_code_i;
      stacc_q <= staccato_i;
    end
    if (state_q == F_OCT) begin
      oct_q  <= oct_d;
      semi_q <= semi_d;
    end
    if (state_q == F_MUL) begin
      prod_q <= 21'(ntse_pkg::beat_24ths(dur_q)) * 21'(spb_i);
    end
    if (state_q == F_LEN) begin
      len_q <= len_d;
    end
    if (state_q == F_REL) begin
      rel_q <= rel_d;
    end
    if (state_q == F_STEP) begin
      step_q <= step_d;
    end
  end

  // Build the queue entry
  always_comb begin
    push_o             = (state_q == F_PUSH) && !full_i;
    push_item_o.cmd    = cmd_q;
    push_item_o.skip   = (pitch_q == ntse_pkg::PITCH_SKIP) || (len_q == '0);
    push_item_o.voiced = !((pitch_q == ntse_pkg::PITCH_REST) || (pitch_q == ntse_pkg::PITCH_NUL));
    push_item_o.step   = push_item_o.voiced ? step_q : '0;
    push_item_o.sus_len = len_q - rel_q;
    push_item_o.rel_len = rel_q;
  end

endmodule

// ===== hdl/ntse_fifo.sv =====
// Short queue of classified transactions between front and back.
// Depends on ntse_pkg.
module ntse_fifo #(
  parameter int DEPTH = ntse_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ntse_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output ntse_pkg::item_t pop_item_o,
  output logic            empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ntse_pkg::item_t slot_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = slot_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ===== hdl/ntse_back.sv =====
// Back part: holds note state, evaluates the sine and envelope, drives results.
// Depends on ntse_pkg and ntse_div.
module ntse_back #(
  parameter int PHASE_BITS      = ntse_pkg::PHASE_BITS_DEF,
  parameter int SINE_INDEX_BITS = ntse_pkg::SINE_INDEX_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  output logic            pop_o,
  input  ntse_pkg::item_t pop_item_i,
  input  logic            empty_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      sample_o,
  output logic            note_last_o,
  output logic            idle_o
);

  localparam int PB = PHASE_BITS;
  localparam int SI = SINE_INDEX_BITS;
  localparam int QB = SI - 2;
  localparam int LW = ntse_pkg::LEN_W;
  localparam int DW = ntse_pkg::BACK_DIV_W;

  typedef enum logic [8:0] {
    B_IDLE  = 9'b000000001,
    B_SQ    = 9'b000000010,
    B_HORN  = 9'b000000100,
    B_SIN   = 9'b000001000,
    B_AMP   = 9'b000010000,
    B_DIV5  = 9'b000100000,
    B_SCALE = 9'b001000000,
    B_DIV   = 9'b010000000,
    B_OUT   = 9'b100000000
  } bstate_e;

  bstate_e state_q, state_d;

  // Note state
  logic [PB-1:0] phase_q, step_q;
  logic [LW-1:0] pos_q, sus_q, rel_q;
  logic          voiced_q, playing_q;

  // Per-sample working registers
  logic [16:0] x_q, x2_q;
  logic [30:0] t_q;
  logic [15:0] amp_q;
  logic [13:0] mag_q;
  logic [1:0]  hcnt_q;
  logic        neg_q, last_q, idle_res_q;
  logic [7:0]  res_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] sample_q;
  logic       note_last_q, idle_q;

  logic [SI-1:0] idx;
  logic [1:0]    quad;
  logic [QB:0]   ufold;
  logic [16:0]   x;
  logic [33:0]   xsq;
  logic [47:0]   hprod, hdiff, sprod, aprod;
  logic [33:0]   d5prod;
  logic [LW-1:0] n_rel, left;
  logic          in_sustain, out_load, tick_pop;
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_divisor, div_quo, div_rem;

  // Fold the phase into a quarter turn
  always_comb begin
    idx   = phase_q[PB-1 -: SI];
    quad  = idx[SI-1:SI-2];
    ufold = quad[0] ? ((QB+1)'(1) << QB) - (QB+1)'(idx[QB-1:0])
                    : (QB+1)'(idx[QB-1:0]);
    x     = 17'(ufold) << (16 - QB);
    xsq   = 34'(x) * 34'(x);
  end

  // Datapath products, one multiply per state
  always_comb begin
    hprod  = 48'(t_q) * 48'(x2_q);
    hdiff  = 48'(ntse_pkg::horner_coef(hcnt_q)) - (hprod >> 16);
    sprod  = (48'(t_q) * 48'(x_q)) >> 16;
    aprod  = 48'(t_q) * 48'(ntse_pkg::AMP_NUM) + 48'(ntse_pkg::AMP_BIAS);
    d5prod = 34'(amp_q) * 34'(ntse_pkg::DIV5_RECIP);
  end

  // Release envelope operands
  always_comb begin
    in_sustain   = (pos_q < sus_q) || (rel_q == '0);
    n_rel        = pos_q - sus_q;
    left         = (n_rel < rel_q) ? rel_q - n_rel : '0;
    div_start    = (state_q == B_SCALE) && !in_sustain;
    div_dividend = DW'(mag_q) * DW'(left);
    div_divisor  = DW'({rel_q, 8'd0});
  end

  ntse_div #(.W(DW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign tick_pop = pop_o && (pop_item_i.cmd == ntse_pkg::CMD_TICK);
  assign out_load = (state_q == B_OUT) && (!out_valid_q || !out_stall_i);

  // Sequence one tick through the wave and envelope
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (tick_pop) begin
          state_d = (playing_q && voiced_q) ? B_SQ : B_OUT;
        end
      end
      B_SQ:    state_d = B_HORN;
      B_HORN:  if (hcnt_q == 2'd3) state_d = B_SIN;
      B_SIN:   state_d = B_AMP;
      B_AMP:   state_d = B_DIV5;
      B_DIV5:  state_d = B_SCALE;
      B_SCALE: state_d = in_sustain ? B_OUT : B_DIV;
      B_DIV:   if (div_done) state_d = B_OUT;
      B_OUT:   if (out_load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Hold note state: loads replace it, delivered ticks advance it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      phase_q     <= '0;
      step_q      <= '0;
      pos_q       <= '0;
      sus_q       <= '0;
      rel_q       <= '0;
      voiced_q    <= 1'b0;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o && (pop_item_i.cmd == ntse_pkg::CMD_LOAD)) begin
        phase_q <= '0;
        pos_q   <= '0;
        if (pop_item_i.skip) begin
          playing_q <= 1'b0;
          voiced_q  <= 1'b0;
          step_q    <= '0;
          sus_q     <= '0;
          rel_q     <= '0;
        end else begin
          playing_q <= 1'b1;
          voiced_q  <= pop_item_i.voiced;
          step_q    <= pop_item_i.step[PB-1:0];
          sus_q     <= pop_item_i.sus_len;
          rel_q     <= pop_item_i.rel_len;
        end
      end
      if (out_load && !idle_res_q) begin
        if (voiced_q) begin
          phase_q <= phase_q + step_q;
        end
        pos_q <= pos_q + 1'b1;
        if (last_q) begin
          playing_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the sample computation
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (tick_pop) begin
          idle_res_q <= !playing_q;
          last_q     <= playing_q && ((17'(pos_q) + 17'd1) >= (17'(sus_q) + 17'(rel_q)));
          neg_q      <= 1'b0;
          res_q      <= '0;
        end
      end
      B_SQ: begin
        x_q    <= x;
        x2_q   <= xsq[32:16];
        neg_q  <= quad[1];
        t_q    <= ntse_pkg::HORNER_INIT;
        hcnt_q <= '0;
      end
      B_HORN: begin
        t_q    <= hdiff[30:0];
        hcnt_q <= hcnt_q + 1'b1;
      end
      B_SIN:   t_q   <= sprod[30:0];
      B_AMP:   amp_q <= aprod[45:30];
      B_DIV5:  mag_q <= d5prod[31:18];
      B_SCALE: if (in_sustain) res_q <= 8'(mag_q >> 8);
      B_DIV:   if (div_done) res_q <= div_quo[7:0];
      default: begin
      end
    endcase
    if (out_load) begin
      sample_q    <= neg_q ? 8'(-res_q) : res_q;
      note_last_q <= last_q;
      idle_q      <= idle_res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign note_last_o = note_last_q;
  assign idle_o      = idle_q;

endmodule
